// ===== hdl/ntdd_pkg.sv =====
// Shared codes and segment pattern table for the display digit formatter.
package ntdd_pkg;

  typedef enum logic [1:0] {
    CMD_UDEC = 2'd0,
    CMD_SDEC = 2'd1,
    CMD_HEX  = 2'd2,
    CMD_FILL = 2'd3
  } cmd_t;

  localparam logic [7:0]  CODE_OVF_DEC = 8'h0B;
  localparam logic [7:0]  CODE_MINUS   = 8'h0A;
  localparam logic [4:0]  HEX_OVF_IDX  = 5'd21;
  localparam logic [7:0]  POINT_BIT    = 8'h80;
  localparam logic [31:0] RECIP_TEN    = 32'hCCCC_CCCD;

  function automatic logic [7:0] seg_pattern(input logic [4:0] idx);
    logic [7:0] pat;
    unique case (idx)
      5'd0:    pat = 8'h7E;
      5'd1:    pat = 8'h30;
      5'd2:    pat = 8'h6D;
      5'd3:    pat = 8'h79;
      5'd4:    pat = 8'h33;
      5'd5:    pat = 8'h5B;
      5'd6:    pat = 8'h5F;
      5'd7:    pat = 8'h70;
      5'd8:    pat = 8'h7F;
      5'd9:    pat = 8'h7B;
      5'd10:   pat = 8'h77;
      5'd11:   pat = 8'h1F;
      5'd12:   pat = 8'h4E;
      5'd13:   pat = 8'h3D;
      5'd14:   pat = 8'h4F;
      5'd15:   pat = 8'h47;
      5'd16:   pat = 8'h01;
      5'd17:   pat = 8'h00;
      5'd18:   pat = 8'h41;
      5'd19:   pat = 8'h36;
      5'd20:   pat = 8'h08;
      default: pat = 8'h49;
    endcase
    return pat;
  endfunction

endpackage

// ===== hdl/number_to_display_digits.sv =====
// Number formatter producing digit-register writes for a multi-digit display.
// One request is taken when req_valid is high and req_stall low; req_stall stays
// high until the last digit write of that request has been loaded into the output
// register. A shared divide-by-ten (reciprocal multiply) or shift-by-four step
// unit produces one digit per cycle, then one write leaves per cycle while the
// output register is not stalled; fill requests skip the digit step. Requests
// that start off the display or have zero length produce no writes.
module number_to_display_digits
  import ntdd_pkg::*;
#(
  parameter int NUM_DIGITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  cmd,
  input  logic [31:0] value,
  input  logic [3:0]  start_req,
  input  logic [3:0]  length,
  input  logic [3:0]  point_pos,
  input  logic [7:0]  fill_code,
  output logic        digit_valid,
  input  logic        digit_stall,
  output logic [2:0]  digit_pos,
  output logic [7:0]  digit_code,
  output logic        last
);

  localparam int         IW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [3:0] ND = 4'(NUM_DIGITS);

  typedef enum logic [1:0] {S_IDLE, S_MINUS, S_CALC, S_EMIT} state_t;

  state_t     state;
  logic [31:0] num;
  logic        hex;
  logic        fill;
  logic        ovf;
  logic [3:0]  st;
  logic [3:0]  nlen;
  logic [3:0]  pt;
  logic [3:0]  cnt;
  logic [7:0]  fcode;
  logic [3:0]  dig [NUM_DIGITS];

  // step unit
  logic [63:0] prod;
  logic [31:0] quo;
  logic [3:0]  rem;
  logic [3:0]  ten_lo;

  always_comb begin
    prod   = num * RECIP_TEN;
    ten_lo = 4'({prod[35], 3'b000}) + 4'({prod[37:35], 1'b0});
    if (hex) begin
      quo = {4'd0, num[31:4]};
      rem = num[3:0];
    end else begin
      quo = {3'd0, prod[63:35]};
      rem = num[3:0] - ten_lo;
    end
  end

  // request decode
  logic [3:0] lim;
  logic [3:0] clen;
  logic       req_drop;

  always_comb begin
    lim      = ND - start_req;
    clen     = (length > lim) ? lim : length;
    req_drop = (start_req >= ND) || (clen == 4'd0);
  end

  // emit path
  logic       can_load;
  logic       load;
  logic       first_ovf;
  logic [3:0] cur_dig;
  logic [4:0] hex_idx;
  logic [7:0] num_code;
  logic [7:0] emit_code;

  always_comb begin
    can_load  = !digit_valid || !digit_stall;
    load      = can_load && ((state == S_MINUS) || (state == S_EMIT));
    cur_dig   = dig[cnt[IW-1:0]];
    first_ovf = ovf && (cnt == 4'd0);
    hex_idx   = first_ovf ? HEX_OVF_IDX : {1'b0, cur_dig};
    if (hex) begin
      num_code = seg_pattern(hex_idx);
    end else begin
      num_code = first_ovf ? CODE_OVF_DEC : {4'd0, cur_dig};
    end
    if (fill) begin
      emit_code = fcode;
    end else begin
      emit_code = num_code | ((cnt == pt) ? POINT_BIT : 8'd0);
    end
  end

  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      digit_valid <= 1'b0;
      cnt         <= 4'd0;
    end else begin
      if (load) begin
        digit_valid <= 1'b1;
      end else if (!digit_stall) begin
        digit_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_valid && !req_drop) begin
            st    <= start_req;
            pt    <= point_pos;
            fcode <= fill_code;
            hex   <= (cmd == CMD_HEX);
            fill  <= (cmd == CMD_FILL);
            cnt   <= 4'd0;
            if (cmd == CMD_FILL) begin
              nlen  <= clen;
              state <= S_EMIT;
            end else if (cmd == CMD_SDEC && value[31]) begin
              num   <= ~value + 32'd1;
              nlen  <= clen - 4'd1;
              state <= S_MINUS;
            end else begin
              num   <= value;
              nlen  <= clen;
              state <= S_CALC;
            end
          end
        end
        S_MINUS: begin
          if (can_load) begin
            digit_pos   <= 3'(st + nlen);
            digit_code  <= CODE_MINUS;
            last        <= (nlen == 4'd0);
            state       <= (nlen == 4'd0) ? S_IDLE : S_CALC;
          end
        end
        S_CALC: begin
          dig[cnt[IW-1:0]] <= rem;
          num              <= quo;
          if (cnt == nlen - 4'd1) begin
            ovf   <= (quo != 32'd0);
            cnt   <= 4'd0;
            state <= S_EMIT;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        S_EMIT: begin
          if (can_load) begin
            digit_pos   <= 3'(st + cnt);
            digit_code  <= emit_code;
            last        <= (cnt == nlen - 4'd1);
            cnt         <= cnt + 4'd1;
            if (cnt == nlen - 4'd1) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_calc_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_CALC) |-> (cnt < nlen))
    else $error("digit counter ran past length");

  a_more_after_nonlast: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && !digit_stall && !last) |-> (state != S_IDLE))
    else $error("non-final write with no writes pending");

  a_dec_digit: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT && !hex && !fill) |-> (cur_dig <= 4'd9))
    else $error("decimal digit out of range");

  a_no_load_while_full: assert property (@(posedge clk) disable iff (rst)
    (digit_valid && digit_stall) |=> digit_valid)
    else $error("pending write dropped");

endmodule
